// File: rtl/core/dfuc_pkg.sv
// ----------------------------------------------------------------------------
// dfuc_pkg
// Shared types and constants of the DFU class request state machine.
// ----------------------------------------------------------------------------
package dfuc_pkg;

  localparam int unsigned BLOCK_BYTES  = 512;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 24;
  localparam int unsigned IN_TDATA_W   = 72;
  localparam int unsigned OUT_TDATA_W  = 80;

  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_NUMBER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DFU_ATTRIBUTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_TIMEOUT_MS = 2'd2;

  localparam logic [7:0]  IFACE_RESET = 8'd255;
  localparam logic [3:0]  ATTR_RESET  = 4'd1;
  localparam logic [23:0] POLL_RESET  = 24'd10;

  localparam int unsigned ATTR_CAN_DNLOAD  = 0;
  localparam int unsigned ATTR_MAN_TOLERANT = 2;

  localparam logic [1:0] RTYPE_CLASS = 2'b01;

  localparam logic [7:0] REQ_DNLOAD    = 8'd1;
  localparam logic [7:0] REQ_GETSTATUS = 8'd3;
  localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
  localparam logic [7:0] REQ_GETSTATE  = 8'd5;
  localparam logic [7:0] REQ_ABORT     = 8'd6;

  localparam logic [3:0] STAT_OK       = 4'd0;
  localparam logic [3:0] STAT_ERR_PROG = 4'd6;

  localparam logic [9:0] STATUS_BYTES = 10'd6;
  localparam logic [9:0] STATE_BYTES  = 10'd1;

  typedef enum logic [1:0] {
    KIND_CTRL       = 2'd0,
    KIND_FLASHED    = 2'd1,
    KIND_MANIFESTED = 2'd2,
    KIND_NONE       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAGE_SETUP  = 2'd0,
    STAGE_DATA   = 2'd1,
    STAGE_STATUS = 2'd2,
    STAGE_OTHER  = 2'd3
  } stage_e;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd2,
    ST_DN_SYNC  = 4'd3,
    ST_DN_BUSY  = 4'd4,
    ST_DN_IDLE  = 4'd5,
    ST_MAN_SYNC = 4'd6,
    ST_MAN      = 4'd7,
    ST_MAN_WAIT = 4'd8,
    ST_ERROR    = 4'd10
  } dfu_state_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ACK    = 3'd1,
    ACT_STATUS = 3'd2,
    ACT_STATE  = 3'd3,
    ACT_RECV   = 3'd4,
    ACT_STALL  = 3'd5
  } action_e;

  typedef struct packed {
    logic [7:0]  iface_number;
    logic [3:0]  dfu_attributes;
    logic [23:0] poll_timeout_ms;
  } cfg_t;

  typedef struct packed {
    kind_e       req_type;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    stage_e      ctrl_stage;
  } item_t;

  typedef struct packed {
    action_e     action;
    logic [9:0]  xfer_bytes;
    logic [3:0]  resp_status;
    logic [3:0]  resp_state;
    logic [23:0] resp_poll_timeout;
    logic        block_ready;
    logic [24:0] block_offset;
    logic [9:0]  block_length;
  } result_t;

endpackage

// File: rtl/core/dfu_class_request_fsm_top.sv
// ----------------------------------------------------------------------------
// dfu_class_request_fsm_top
// DFU 1.1 class request handler: one control event in, one response out.
// ----------------------------------------------------------------------------
// Input channel s_axis_*: one event per item (control request at one stage
// of a control transfer, or an application report in tuser). Output channel
// m_axis_*: one response item per event (action in tuser, fields in tdata).
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// no event is in flight; index 0 interface number, 1 attributes, 2 poll
// timeout.
// Latency: an accepted item is held in the input register and decoded against
// the DFU state; its response is registered in the output register once that
// register is free, which raises m_axis_tvalid.
// Throughput: one item per cycle while m_axis_tready stays high; the state
// registers update in the same cycle as the response is registered, so consecutive items chain directly.
// Stall: when m_axis_tready is low the response is held, the input register
// keeps its item and s_axis_tready drops once both registers are full.
// Reset: state dfuIDLE, status OK, registers back to their defaults, both
// channel registers empty.
// ----------------------------------------------------------------------------
module dfu_class_request_fsm_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dfuc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dfuc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // request_type, request_code, request_value, request_index,
  // request_length, ctrl_stage, zero pad
  input  logic [dfuc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // xfer_bytes, resp_status, resp_state, resp_poll_timeout, block_ready,
  // block_offset, block_length, zero pad
  output logic [dfuc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // action
  output logic [2:0]                           m_axis_tuser
);

  dfuc_pkg::cfg_t    cfg;
  dfuc_pkg::item_t   item_q, item_d;
  dfuc_pkg::result_t res_d, res_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              step;

  dfuc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_comb begin
    item_d.req_type       = dfuc_pkg::kind_e'(s_axis_tuser);
    item_d.request_type   = s_axis_tdata[7:0];
    item_d.request_code   = s_axis_tdata[15:8];
    item_d.request_value  = s_axis_tdata[31:16];
    item_d.request_index  = s_axis_tdata[47:32];
    item_d.request_length = s_axis_tdata[63:48];
    item_d.ctrl_stage     = dfuc_pkg::stage_e'(s_axis_tdata[65:64]);
  end

  dfuc_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (step)          out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) item_q <= item_d;
    if (step)                           res_q  <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.action;
  assign m_axis_tdata  = {2'b00,
                          res_q.block_length,
                          res_q.block_offset,
                          res_q.block_ready,
                          res_q.resp_poll_timeout,
                          res_q.resp_state,
                          res_q.resp_status,
                          res_q.xfer_bytes};

endmodule

// File: rtl/core/dfuc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dfuc_cfg_regs
// Configuration registers written through a plain index/data write port.
// ----------------------------------------------------------------------------
module dfuc_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dfuc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dfuc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output dfuc_pkg::cfg_t                     cfg_o
);

  dfuc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfuc_pkg::CFG_IFACE_NUMBER:    cfg_d.iface_number    = cfg_wdata_i[7:0];
        dfuc_pkg::CFG_DFU_ATTRIBUTES:  cfg_d.dfu_attributes  = cfg_wdata_i[3:0];
        dfuc_pkg::CFG_POLL_TIMEOUT_MS: cfg_d.poll_timeout_ms = cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.iface_number    <= dfuc_pkg::IFACE_RESET;
      cfg_q.dfu_attributes  <= dfuc_pkg::ATTR_RESET;
      cfg_q.poll_timeout_ms <= dfuc_pkg::POLL_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/dfuc_fsm.sv
// ----------------------------------------------------------------------------
// dfuc_fsm
// DFU state and status registers with the request decode of one item.
// ----------------------------------------------------------------------------
module dfuc_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  dfuc_pkg::item_t      item_i,
  input  dfuc_pkg::cfg_t       cfg_i,
  output dfuc_pkg::result_t    result_o
);

  dfuc_pkg::dfu_state_e state_q, state_d;
  logic [3:0]           status_q, status_d;
  logic                 man_done_q, man_done_d;

  logic        addressed;
  logic        sent;
  logic        can_dnload;
  logic        tolerant;
  logic [24:0] offset_full;

  assign can_dnload  = cfg_i.dfu_attributes[dfuc_pkg::ATTR_CAN_DNLOAD];
  assign tolerant    = cfg_i.dfu_attributes[dfuc_pkg::ATTR_MAN_TOLERANT];
  assign addressed   = (item_i.request_type[6:5] == dfuc_pkg::RTYPE_CLASS) &&
                       (item_i.request_index == {8'd0, cfg_i.iface_number});
  assign offset_full = 25'(item_i.request_value) * 25'(dfuc_pkg::BLOCK_BYTES);

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    man_done_d = man_done_q;
    sent       = 1'b0;
    result_o   = '0;
    result_o.action = dfuc_pkg::ACT_NONE;

    unique case (item_i.req_type)
      dfuc_pkg::KIND_FLASHED: begin
        if (state_q == dfuc_pkg::ST_DN_BUSY) state_d = dfuc_pkg::ST_DN_IDLE;
      end
      dfuc_pkg::KIND_MANIFESTED: begin
        if (state_q == dfuc_pkg::ST_MAN) begin
          man_done_d = 1'b1;
          state_d    = tolerant ? dfuc_pkg::ST_MAN_SYNC : dfuc_pkg::ST_MAN_WAIT;
        end
      end
      dfuc_pkg::KIND_CTRL: begin
        if (addressed) begin
          if (item_i.request_type[7]) begin
            priority if (item_i.ctrl_stage == dfuc_pkg::STAGE_DATA) begin
              result_o.action = dfuc_pkg::ACT_ACK;
            end else if (item_i.request_code == dfuc_pkg::REQ_GETSTATUS) begin
              result_o.action            = dfuc_pkg::ACT_STATUS;
              result_o.xfer_bytes        = dfuc_pkg::STATUS_BYTES;
              result_o.resp_poll_timeout = cfg_i.poll_timeout_ms;
              sent                       = 1'b1;
              if (state_q == dfuc_pkg::ST_DN_SYNC) begin
                state_d = dfuc_pkg::ST_DN_BUSY;
              end else if (state_q == dfuc_pkg::ST_MAN_SYNC) begin
                priority if (!man_done_q) state_d = dfuc_pkg::ST_MAN;
                else if (tolerant)        state_d = dfuc_pkg::ST_IDLE;
                else                      state_d = dfuc_pkg::ST_MAN_WAIT;
              end
            end else if (item_i.request_code == dfuc_pkg::REQ_GETSTATE) begin
              result_o.action     = dfuc_pkg::ACT_STATE;
              result_o.xfer_bytes = dfuc_pkg::STATE_BYTES;
              sent                = 1'b1;
            end else begin
              result_o.action = dfuc_pkg::ACT_STALL;
              state_d         = dfuc_pkg::ST_ERROR;
            end
          end else begin
            priority if (item_i.request_code == dfuc_pkg::REQ_CLRSTATUS) begin
              if (state_q == dfuc_pkg::ST_ERROR || status_q != dfuc_pkg::STAT_OK) begin
                status_d = dfuc_pkg::STAT_OK;
                state_d  = dfuc_pkg::ST_IDLE;
              end
              result_o.action = dfuc_pkg::ACT_ACK;
            end else if (item_i.request_code == dfuc_pkg::REQ_ABORT) begin
              state_d         = dfuc_pkg::ST_IDLE;
              result_o.action = dfuc_pkg::ACT_ACK;
            end else if (item_i.request_code == dfuc_pkg::REQ_DNLOAD) begin
              priority if (!can_dnload) begin
                state_d         = dfuc_pkg::ST_ERROR;
                result_o.action = dfuc_pkg::ACT_STALL;
              end else if (state_q != dfuc_pkg::ST_IDLE &&
                           state_q != dfuc_pkg::ST_DN_IDLE) begin
                status_d        = dfuc_pkg::STAT_ERR_PROG;
                state_d         = dfuc_pkg::ST_ERROR;
                result_o.action = dfuc_pkg::ACT_STALL;
              end else if (item_i.request_length == '0 &&
                           state_q == dfuc_pkg::ST_IDLE) begin
                status_d        = dfuc_pkg::STAT_ERR_PROG;
                state_d         = dfuc_pkg::ST_ERROR;
                result_o.action = dfuc_pkg::ACT_STALL;
              end else if (item_i.request_length == '0) begin
                man_done_d      = 1'b0;
                state_d         = dfuc_pkg::ST_MAN_SYNC;
                result_o.action = dfuc_pkg::ACT_ACK;
              end else if (32'(item_i.request_length) > 32'(dfuc_pkg::BLOCK_BYTES)) begin
                status_d        = dfuc_pkg::STAT_ERR_PROG;
                state_d         = dfuc_pkg::ST_ERROR;
                result_o.action = dfuc_pkg::ACT_STALL;
              end else if (item_i.ctrl_stage == dfuc_pkg::STAGE_SETUP) begin
                result_o.action     = dfuc_pkg::ACT_RECV;
                result_o.xfer_bytes = item_i.request_length[9:0];
              end else begin
                state_d               = dfuc_pkg::ST_DN_SYNC;
                result_o.action       = dfuc_pkg::ACT_ACK;
                result_o.block_ready  = 1'b1;
                result_o.block_offset = offset_full;
                result_o.block_length = item_i.request_length[9:0];
              end
            end else begin
              result_o.action = dfuc_pkg::ACT_STALL;
              state_d         = dfuc_pkg::ST_ERROR;
            end
          end
        end
      end
      default: ;
    endcase

    result_o.resp_status = sent ? status_q : status_d;
    result_o.resp_state  = sent ? state_q  : state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dfuc_pkg::ST_IDLE;
      status_q   <= dfuc_pkg::STAT_OK;
      man_done_q <= 1'b0;
    end else if (step_i) begin
      state_q    <= state_d;
      status_q   <= status_d;
      man_done_q <= man_done_d;
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DFU class request state machine.
// A directed table walks the download, manifestation, error and filtering
// paths at the register defaults. Six random phases follow under different
// register settings and idle patterns. Stimulus is mostly request sequences
// that follow the DFU state, with noise and broken sequences mixed in. Every
// response is compared field by field against its fixed table entry or, for
// the other items, against an in-bench model of the state machine.
// ----------------------------------------------------------------------------
module tb;
  import dfuc_pkg::*;

  localparam logic [7:0]  RT_CLASS_OUT  = 8'h21;
  localparam logic [7:0]  RT_CLASS_IN   = 8'hA1;
  localparam logic [7:0]  RT_VENDOR_OUT = 8'h41;
  localparam logic [7:0]  REQ_DETACH    = 8'd0;
  localparam logic [7:0]  REQ_UPLOAD    = 8'd2;
  localparam logic [15:0] IF_AT_RESET   = {8'd0, IFACE_RESET};
  localparam int          NUM_PHASES    = 6;
  localparam int          HOLD_CYCLES   = 60;

  typedef struct {
    item_t   it;
    bit      fixed;
    result_t resp;
  } stim_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]       cfg_wdata_i = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [IN_TDATA_W-1:0]       s_axis_tdata = '0;
  logic [1:0]                  s_axis_tuser = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]      m_axis_tdata;
  logic [2:0]                  m_axis_tuser;

  dfu_state_e  dfu_state_q;
  logic [3:0]  dfu_status_q;
  bit          manifest_done_q;
  logic [24:0] block_offset_q;
  logic [9:0]  block_length_q;
  logic [7:0]  cfg_iface;
  logic [3:0]  cfg_attr;
  logic [23:0] cfg_poll;

  result_t     resp_expected[$];
  stim_row_t   directed_rows[$];
  result_t     want;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          mismatch_cnt = 0;
  int          items_sent = 0;
  int          resp_checked = 0;
  int          blocks_seen = 0;

  dfu_class_request_fsm_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic item_t mk_item(kind_e k, logic [7:0] rt, logic [7:0] code,
                                    logic [15:0] val, logic [15:0] idx,
                                    logic [15:0] len, stage_e stg);
    item_t it;
    it.req_type       = k;
    it.request_type   = rt;
    it.request_code   = code;
    it.request_value  = val;
    it.request_index  = idx;
    it.request_length = len;
    it.ctrl_stage     = stg;
    return it;
  endfunction

  function automatic result_t mk_resp(action_e a, logic [9:0] nb, logic [3:0] stat,
                                      dfu_state_e st, logic [23:0] poll, logic rdy,
                                      logic [24:0] off, logic [9:0] len);
    result_t r;
    r.action            = a;
    r.xfer_bytes        = nb;
    r.resp_status       = stat;
    r.resp_state        = st;
    r.resp_poll_timeout = poll;
    r.block_ready       = rdy;
    r.block_offset      = off;
    r.block_length      = len;
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_item(item_t it);
    return {6'd0, it.ctrl_stage, it.request_length, it.request_index,
            it.request_value, it.request_code, it.request_type};
  endfunction

  function automatic void reset_dfu_model();
    dfu_state_q     = ST_IDLE;
    dfu_status_q    = STAT_OK;
    manifest_done_q = 1'b0;
    block_offset_q  = '0;
    block_length_q  = '0;
    cfg_iface       = IFACE_RESET;
    cfg_attr        = ATTR_RESET;
    cfg_poll        = POLL_RESET;
  endfunction

  function automatic result_t predict_dfu_event(item_t it);
    result_t    r;
    bit         sent;
    logic [3:0] sent_status;
    logic [3:0] sent_state;
    r = '0;
    sent = 1'b0;
    sent_status = '0;
    sent_state = '0;
    if (it.req_type == KIND_FLASHED) begin
      if (dfu_state_q == ST_DN_BUSY) dfu_state_q = ST_DN_IDLE;
    end else if (it.req_type == KIND_MANIFESTED) begin
      if (dfu_state_q == ST_MAN) begin
        manifest_done_q = 1'b1;
        dfu_state_q = cfg_attr[ATTR_MAN_TOLERANT] ? ST_MAN_SYNC : ST_MAN_WAIT;
      end
    end else if (it.req_type == KIND_CTRL && it.request_type[6:5] == RTYPE_CLASS &&
                 it.request_index == {8'd0, cfg_iface}) begin
      if (it.request_type[7]) begin
        if (it.ctrl_stage == STAGE_DATA) begin
          r.action = ACT_ACK;
        end else if (it.request_code == REQ_GETSTATUS) begin
          r.action = ACT_STATUS;
          r.xfer_bytes = STATUS_BYTES;
          r.resp_poll_timeout = cfg_poll;
          sent = 1'b1;
          sent_status = dfu_status_q;
          sent_state = dfu_state_q;
          if (dfu_state_q == ST_DN_SYNC) begin
            dfu_state_q = ST_DN_BUSY;
          end else if (dfu_state_q == ST_MAN_SYNC) begin
            if (!manifest_done_q) dfu_state_q = ST_MAN;
            else if (cfg_attr[ATTR_MAN_TOLERANT]) dfu_state_q = ST_IDLE;
            else dfu_state_q = ST_MAN_WAIT;
          end
        end else if (it.request_code == REQ_GETSTATE) begin
          r.action = ACT_STATE;
          r.xfer_bytes = STATE_BYTES;
          sent = 1'b1;
          sent_status = dfu_status_q;
          sent_state = dfu_state_q;
        end else begin
          r.action = ACT_STALL;
          dfu_state_q = ST_ERROR;
        end
      end else begin
        case (it.request_code)
          REQ_CLRSTATUS: begin
            if (dfu_state_q == ST_ERROR || dfu_status_q != STAT_OK) begin
              dfu_status_q = STAT_OK;
              dfu_state_q = ST_IDLE;
            end
            r.action = ACT_ACK;
          end
          REQ_ABORT: begin
            block_offset_q = '0;
            dfu_state_q = ST_IDLE;
            r.action = ACT_ACK;
          end
          REQ_DNLOAD: begin
            if (!cfg_attr[ATTR_CAN_DNLOAD]) begin
              dfu_state_q = ST_ERROR;
              r.action = ACT_STALL;
            end else if (dfu_state_q != ST_IDLE && dfu_state_q != ST_DN_IDLE) begin
              dfu_status_q = STAT_ERR_PROG;
              dfu_state_q = ST_ERROR;
              r.action = ACT_STALL;
            end else if (it.request_length == 16'd0) begin
              if (dfu_state_q == ST_IDLE) begin
                dfu_status_q = STAT_ERR_PROG;
                dfu_state_q = ST_ERROR;
                r.action = ACT_STALL;
              end else begin
                manifest_done_q = 1'b0;
                dfu_state_q = ST_MAN_SYNC;
                r.action = ACT_ACK;
              end
            end else if (it.request_length > BLOCK_BYTES) begin
              dfu_status_q = STAT_ERR_PROG;
              dfu_state_q = ST_ERROR;
              r.action = ACT_STALL;
            end else if (it.ctrl_stage == STAGE_SETUP) begin
              r.action = ACT_RECV;
              r.xfer_bytes = it.request_length[9:0];
            end else begin
              block_offset_q = 25'(it.request_value * BLOCK_BYTES);
              block_length_q = it.request_length[9:0];
              dfu_state_q = ST_DN_SYNC;
              r.action = ACT_ACK;
              r.block_ready = 1'b1;
              r.block_offset = block_offset_q;
              r.block_length = block_length_q;
            end
          end
          default: begin
            r.action = ACT_STALL;
            dfu_state_q = ST_ERROR;
          end
        endcase
      end
    end
    if (!sent) begin
      sent_status = dfu_status_q;
      sent_state = dfu_state_q;
    end
    r.resp_status = sent_status;
    r.resp_state = sent_state;
    return r;
  endfunction

  function automatic item_t next_request();
    item_t       it;
    int unsigned roll;
    it.req_type       = KIND_CTRL;
    it.request_type   = {1'b0, RTYPE_CLASS, 5'($urandom)};
    it.request_code   = REQ_GETSTATUS;
    it.request_value  = 16'($urandom);
    it.request_index  = {8'd0, cfg_iface};
    it.request_length = 16'($urandom_range(1, BLOCK_BYTES));
    it.ctrl_stage     = stage_e'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 70) begin
      case (dfu_state_q)
        ST_IDLE, ST_DN_IDLE: begin
          it.request_code = REQ_DNLOAD;
          it.ctrl_stage = ($urandom_range(0, 2) == 0) ? STAGE_SETUP :
                          stage_e'($urandom_range(1, 3));
          if (dfu_state_q == ST_DN_IDLE && $urandom_range(0, 4) == 0)
            it.request_length = 16'd0;
        end
        ST_DN_SYNC, ST_MAN_SYNC: begin
          it.request_type[7] = 1'b1;
          if (it.ctrl_stage == STAGE_DATA) it.ctrl_stage = STAGE_SETUP;
          if ($urandom_range(0, 5) == 0) it.request_code = REQ_GETSTATE;
        end
        ST_DN_BUSY: it.req_type = KIND_FLASHED;
        ST_MAN: it.req_type = KIND_MANIFESTED;
        ST_MAN_WAIT: it.request_code = REQ_ABORT;
        default: it.request_code = REQ_CLRSTATUS;
      endcase
      return it;
    end
    roll = $urandom_range(0, 9);
    case (roll)
      0: begin
        it.req_type = kind_e'($urandom_range(0, 3));
        it.request_type = 8'($urandom);
        it.request_code = 8'($urandom);
        it.request_length = 16'($urandom);
        if ($urandom_range(0, 1) == 0) it.request_index = 16'($urandom);
      end
      1: begin
        it.request_type[7] = 1'($urandom);
        it.request_code = 8'($urandom);
        it.request_length = 16'($urandom);
      end
      2: begin
        it.request_code = REQ_DNLOAD;
        case ($urandom_range(0, 2))
          0: it.request_length = 16'd0;
          1: it.request_length = 16'(BLOCK_BYTES + 1);
          default: it.request_length = 16'($urandom);
        endcase
      end
      3: begin
        it.request_type[7] = 1'b1;
        it.request_code = REQ_GETSTATE;
      end
      4: it.request_type[7] = 1'b1;
      5: it.request_code = REQ_CLRSTATUS;
      6: it.request_code = REQ_ABORT;
      7: begin
        it.request_type[7] = 1'($urandom);
        it.request_code = it.request_type[7] ? REQ_UPLOAD : REQ_DETACH;
      end
      8: it.req_type = kind_e'($urandom_range(1, 3));
      default: it.request_index = {8'd0, cfg_iface} ^ (16'd1 << $urandom_range(0, 15));
    endcase
    return it;
  endfunction

  task automatic add_fixed(item_t it, result_t r);
    stim_row_t row;
    row.it = it;
    row.fixed = 1'b1;
    row.resp = r;
    directed_rows.push_back(row);
  endtask

  task automatic add_free(item_t it);
    stim_row_t row;
    row.it = it;
    row.fixed = 1'b0;
    row.resp = '0;
    directed_rows.push_back(row);
  endtask

  task automatic send_item(item_t it, bit fixed, result_t typed, output action_e act);
    result_t pred;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_item(it);
    s_axis_tuser  <= it.req_type;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_dfu_event(it);
    resp_expected.push_back(fixed ? typed : pred);
    act = pred.action;
    items_sent++;
    if (pred.block_ready) blocks_seen++;
  endtask

  task automatic drain_responses();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (resp_expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_config(logic [7:0] iface, logic [3:0] attr, logic [23:0] poll);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_IFACE_NUMBER;
    cfg_wdata_i <= {16'd0, iface};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_DFU_ATTRIBUTES;
    cfg_wdata_i <= {20'd0, attr};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_POLL_TIMEOUT_MS;
    cfg_wdata_i <= poll;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_iface = iface;
    cfg_attr  = attr;
    cfg_poll  = poll;
  endtask

  task automatic cmp_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (resp_expected.size() == 0) begin
        $error("response with none outstanding: action %0d", m_axis_tuser);
        mismatch_cnt++;
      end else begin
        want = resp_expected.pop_front();
        resp_checked++;
        cmp_field("action", want.action, m_axis_tuser);
        cmp_field("xfer_bytes", want.xfer_bytes, m_axis_tdata[9:0]);
        cmp_field("resp_status", want.resp_status, m_axis_tdata[13:10]);
        cmp_field("resp_state", want.resp_state, m_axis_tdata[17:14]);
        cmp_field("resp_poll_timeout", want.resp_poll_timeout, m_axis_tdata[41:18]);
        cmp_field("block_ready", want.block_ready, m_axis_tdata[42]);
        cmp_field("block_offset", want.block_offset, m_axis_tdata[67:43]);
        cmp_field("block_length", want.block_length, m_axis_tdata[77:68]);
      end
    end
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  initial begin
    action_e     act;
    item_t       it;
    int unsigned counted;
    int unsigned n;
    int unsigned ph_items;

    reset_dfu_model();

    add_fixed(mk_item(KIND_CTRL, RT_CLASS_IN, REQ_GETSTATUS, 16'd0, IF_AT_RESET, 16'd6,
                      STAGE_SETUP),
              mk_resp(ACT_STATUS, STATUS_BYTES, STAT_OK, ST_IDLE, POLL_RESET, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_IN, REQ_GETSTATE, 16'd0, IF_AT_RESET, 16'd1,
                      STAGE_SETUP),
              mk_resp(ACT_STATE, STATE_BYTES, STAT_OK, ST_IDLE, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_VENDOR_OUT, REQ_DNLOAD, 16'd0, IF_AT_RESET, 16'd0,
                      STAGE_SETUP),
              mk_resp(ACT_NONE, 0, STAT_OK, ST_IDLE, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_IN, REQ_GETSTATUS, 16'd0, 16'hFFFF, 16'd6,
                      STAGE_SETUP),
              mk_resp(ACT_NONE, 0, STAT_OK, ST_IDLE, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_DNLOAD, 16'd0, IF_AT_RESET, 16'd0,
                      STAGE_SETUP),
              mk_resp(ACT_STALL, 0, STAT_ERR_PROG, ST_ERROR, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_IN, REQ_GETSTATUS, 16'd0, IF_AT_RESET, 16'd6,
                      STAGE_SETUP),
              mk_resp(ACT_STATUS, STATUS_BYTES, STAT_ERR_PROG, ST_ERROR, POLL_RESET, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_CLRSTATUS, 16'd0, IF_AT_RESET, 16'd0,
                      STAGE_STATUS),
              mk_resp(ACT_ACK, 0, STAT_OK, ST_IDLE, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_DNLOAD, 16'd0, IF_AT_RESET, 16'hFFFF,
                      STAGE_SETUP),
              mk_resp(ACT_STALL, 0, STAT_ERR_PROG, ST_ERROR, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_ABORT, 16'd0, IF_AT_RESET, 16'd0,
                      STAGE_SETUP),
              mk_resp(ACT_ACK, 0, STAT_ERR_PROG, ST_IDLE, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_CLRSTATUS, 16'd0, IF_AT_RESET, 16'd0,
                      STAGE_SETUP),
              mk_resp(ACT_ACK, 0, STAT_OK, ST_IDLE, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_DNLOAD, 16'hFFFF, IF_AT_RESET, 16'd512,
                      STAGE_SETUP),
              mk_resp(ACT_RECV, 10'd512, STAT_OK, ST_IDLE, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_DNLOAD, 16'hFFFF, IF_AT_RESET, 16'd512,
                      STAGE_DATA),
              mk_resp(ACT_ACK, 0, STAT_OK, ST_DN_SYNC, 0, 1, 25'h1FFFE00, 10'd512));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_IN, REQ_GETSTATE, 16'd0, IF_AT_RESET, 16'd1,
                      STAGE_DATA),
              mk_resp(ACT_ACK, 0, STAT_OK, ST_DN_SYNC, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_IN, REQ_GETSTATUS, 16'd0, IF_AT_RESET, 16'd6,
                      STAGE_STATUS),
              mk_resp(ACT_STATUS, STATUS_BYTES, STAT_OK, ST_DN_SYNC, POLL_RESET, 0, 0, 0));
    add_fixed(mk_item(KIND_NONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, STAGE_OTHER),
              mk_resp(ACT_NONE, 0, STAT_OK, ST_DN_BUSY, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_FLASHED, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, STAGE_SETUP),
              mk_resp(ACT_NONE, 0, STAT_OK, ST_DN_IDLE, 0, 0, 0, 0));
    add_free(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_DNLOAD, 16'd0, IF_AT_RESET, 16'd1,
                     STAGE_OTHER));
    add_free(mk_item(KIND_CTRL, RT_CLASS_IN, REQ_GETSTATUS, 16'd0, IF_AT_RESET, 16'd6,
                     STAGE_SETUP));
    add_free(mk_item(KIND_FLASHED, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, STAGE_SETUP));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_DNLOAD, 16'd0, IF_AT_RESET, 16'd0,
                      STAGE_DATA),
              mk_resp(ACT_ACK, 0, STAT_OK, ST_MAN_SYNC, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_IN, REQ_GETSTATUS, 16'd0, IF_AT_RESET, 16'd6,
                      STAGE_SETUP),
              mk_resp(ACT_STATUS, STATUS_BYTES, STAT_OK, ST_MAN_SYNC, POLL_RESET, 0, 0, 0));
    add_fixed(mk_item(KIND_MANIFESTED, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, STAGE_SETUP),
              mk_resp(ACT_NONE, 0, STAT_OK, ST_MAN_WAIT, 0, 0, 0, 0));
    add_fixed(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_DNLOAD, 16'd3, IF_AT_RESET, 16'd8,
                      STAGE_SETUP),
              mk_resp(ACT_STALL, 0, STAT_ERR_PROG, ST_ERROR, 0, 0, 0, 0));
    add_free(mk_item(KIND_CTRL, RT_CLASS_IN, REQ_UPLOAD, 16'd0, IF_AT_RESET, 16'd64,
                     STAGE_SETUP));
    add_free(mk_item(KIND_CTRL, RT_CLASS_OUT, REQ_DETACH, 16'd1000, IF_AT_RESET, 16'd0,
                     STAGE_SETUP));
    add_free(mk_item(KIND_CTRL, 8'hBF, 8'hFF, 16'hFFFF, IF_AT_RESET, 16'hFFFF, STAGE_OTHER));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].resp, act);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_responses();
      case (ph)
        0: apply_config(8'd0, 4'd1, 24'd0);
        1: apply_config(8'hFF, 4'hF, 24'hFFFFFF);
        2: apply_config(8'($urandom), 4'd5, 24'($urandom));
        3: apply_config(8'd1, 4'd0, 24'd1);
        4: apply_config(8'($urandom), 4'($urandom), 24'($urandom));
        default: apply_config(8'd42, 4'd13, POLL_RESET);
      endcase
      snd_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 84 : 0;
      rcv_idle_pct <= (ph < 2) ? 84 : (ph < 4) ? 18 : 0;
      ph_items = (ph == 3) ? 80 : (ph == 5) ? 120 : 260;
      counted = 0;
      n = 0;
      while (counted < ph_items) begin
        if (ph == 4 && n == 40) hold_req <= 1'b1;
        if (ph == 4 && n == 150) drain_responses();
        it = next_request();
        send_item(it, 1'b0, '0, act);
        n++;
        if (act != ACT_NONE || it.req_type == KIND_FLASHED || it.req_type == KIND_MANIFESTED)
          counted++;
      end
    end

    drain_responses();
    $display("Sent %0d items over %0d register settings; %0d responses checked.",
             items_sent, NUM_PHASES + 1, resp_checked);
    $display("%0d download blocks accepted, %0d mismatches.", blocks_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && resp_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/dfuc_pkg.sv
rtl/core/dfuc_cfg_regs.sv
rtl/core/dfuc_fsm.sv
rtl/core/dfu_class_request_fsm_top.sv
verif/tb.sv
